### rtl/single_source_shortest_path_assert.svh
// Assertion macros shared by the shortest path RTL.
// Depends on nothing; files that assert include this header.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ssp_pkg.sv
// Package for the single-source shortest path block: transaction types,
// operation codes, sequencer states and default sizes. Depends on nothing.
`default_nettype none

package ssp_pkg;

	localparam int DEF_MAX_NODES   = 32;
	localparam int DEF_MAX_EDGES   = 256;
	localparam int DEF_WEIGHT_BITS = 16;

	localparam int          DIST_W           = 24;
	localparam logic [23:0] DIST_MAX         = 24'hFFFFFF;
	localparam logic [5:0]  NODE_COUNT_RESET = 6'd32;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  from_node;
		logic [4:0]  to_node;
		logic [15:0] edge_weight;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  node;
		logic [23:0] distance;
		logic [4:0]  predecessor;
		logic        reachable;
		logic        last;
	} result_t;

	// Commands from the sequencer to the edge store.
	typedef struct packed {
		logic load;
		logic clear;
		logic rd_en;
	} edge_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_EDGE_RD,
		ST_EDGE_CHK,
		ST_DIST_CHK,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### rtl/ssp_edge_store.sv
// Edge store: a synchronous memory of directed weighted edges in load order
// plus the fill count. Depends on ssp_pkg.
`default_nettype none

module ssp_edge_store import ssp_pkg::*; #(
	parameter int MAX_EDGES   = DEF_MAX_EDGES,
	parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
	localparam int EADDR_W    = $clog2(MAX_EDGES),
	localparam int ECNT_W     = $clog2(MAX_EDGES + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire edge_ctrl_t             ctrl,
	input  wire logic [4:0]             wr_from,
	input  wire logic [4:0]             wr_to,
	input  wire logic [WEIGHT_BITS-1:0] wr_weight,
	input  wire logic [EADDR_W-1:0]     rd_addr,
	output      logic [4:0]             rd_from,
	output      logic [4:0]             rd_to,
	output      logic [WEIGHT_BITS-1:0] rd_weight,
	output      logic [ECNT_W-1:0]      total
);

	localparam int WORD_W = 10 + WEIGHT_BITS;

	logic [WORD_W-1:0] mem [MAX_EDGES];
	logic [WORD_W-1:0] rd_q;
	logic [ECNT_W-1:0] total_q;
	logic              full;

	assign full = (total_q == ECNT_W'(MAX_EDGES));

	// Fill count: a load past capacity is dropped, a clear empties the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctrl.clear) begin
			total_q <= '0;
		end else if (ctrl.load && !full) begin
			total_q <= total_q + 1'b1;
		end
	end

	// Memory write at the fill count, registered read.
	always_ff @(posedge clk) begin
		if (ctrl.load && !full) begin
			mem[total_q[EADDR_W-1:0]] <= {wr_from, wr_to, wr_weight};
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_from   = rd_q[WORD_W-1 -: 5];
	assign rd_to     = rd_q[WEIGHT_BITS +: 5];
	assign rd_weight = rd_q[WEIGHT_BITS-1:0];
	assign total     = total_q;

endmodule

`default_nettype wire

### rtl/single_source_shortest_path.sv
// Top level of the single-source shortest path block: command channel,
// run sequencer and per-node distance memory. Depends on ssp_pkg,
// ssp_edge_store and single_source_shortest_path_assert.svh.
//
// Usage: a command transaction is taken at a clock edge with start high and
// busy low. A load stores one edge (dropped once the store is full), a clear
// empties the store; both finish in that cycle and leave busy low, so loads
// go at one per cycle. A run raises busy, walks the graph and then emits one
// result per node in use, node 0 first, each for exactly one cycle with
// result_strobe high; last marks the final one. Busy falls after it, once
// the output pass ends. Each settle pass scans the node distance memory
// one entry a cycle, then reads every stored edge in load order and, for
// each edge that passes the node filter, reads the target's distance; a
// last scan finds nothing and the output pass reads one node a cycle.
// The single read port of each memory keeps these steps apart. The
// receiver cannot stall. Node count is written on its own channel while
// busy is low.
// Reset clears the edge count, the sequencer and sets node count to 32.
`default_nettype none

module single_source_shortest_path import ssp_pkg::*; #(
	parameter int MAX_NODES   = DEF_MAX_NODES,
	parameter int MAX_EDGES   = DEF_MAX_EDGES,
	parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output      logic       busy,
	input  wire cmd_t       cmd,
	output      result_t    result,
	output      logic       result_strobe,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic [5:0] cfg_data
);

	`include "single_source_shortest_path_assert.svh"

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int CNT_W   = $clog2(MAX_NODES + 1);
	localparam int EADDR_W = $clog2(MAX_EDGES);
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
	localparam int SUM_W   = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

	state_t state_q, state_d;

	logic [5:0]           node_count_q;
	logic [CNT_W-1:0]     n_eff, n_q;
	logic                 accept;

	// Node state: distance and predecessor in memory, flags in flip-flops.
	logic [DIST_W-1:0]    dist_mem [MAX_NODES];
	logic [NODE_W-1:0]    pred_mem [MAX_NODES];
	logic [DIST_W-1:0]    dist_rd_q;
	logic [NODE_W-1:0]    pred_rd_q;
	logic [MAX_NODES-1:0] reached_q, settled_q;
	logic                 mem_rd;
	logic [NODE_W-1:0]    mem_rd_addr;
	logic                 mem_we;
	logic [NODE_W-1:0]    mem_wr_addr;
	logic [DIST_W-1:0]    mem_wr_dist;
	logic [NODE_W-1:0]    mem_wr_pred;

	// Source of the current run and whether it lies among the nodes in use.
	logic                 src_ok_q;
	logic [NODE_W-1:0]    src_q;

	// Scan, relax and output bookkeeping.
	logic [CNT_W-1:0]     idx_q;
	logic                 v_s1;
	logic [NODE_W-1:0]    idx_s1;
	logic [NODE_W-1:0]    best_q;
	logic [DIST_W-1:0]    best_dist_q;
	logic                 found_q;
	logic [ECNT_W-1:0]    e_q;
	logic [NODE_W-1:0]    tgt_q;
	logic [DIST_W-1:0]    cand_q;
	logic [SUM_W-1:0]     sum;
	logic                 edge_match;
	logic                 scan_take;
	logic                 scan_done;
	logic                 out_done;

	edge_ctrl_t           ectrl;
	logic [4:0]           e_from, e_to;
	logic [WEIGHT_BITS-1:0] e_weight;
	logic [ECNT_W-1:0]    e_total;

	ssp_edge_store #(
		.MAX_EDGES  (MAX_EDGES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_edges (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ectrl),
		.wr_from  (cmd.from_node),
		.wr_to    (cmd.to_node),
		.wr_weight(WEIGHT_BITS'(cmd.edge_weight)),
		.rd_addr  (e_q[EADDR_W-1:0]),
		.rd_from  (e_from),
		.rd_to    (e_to),
		.rd_weight(e_weight),
		.total    (e_total)
	);

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// Node count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// Effective node count: zero acts as one, large values clamp.
	always_comb begin
		if (node_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(node_count_q) > MAX_NODES) begin
			n_eff = CNT_W'(MAX_NODES);
		end else begin
			n_eff = CNT_W'(node_count_q);
		end
	end

	// Relax candidate and edge filter.
	always_comb begin
		sum = SUM_W'(best_dist_q) + SUM_W'(e_weight);
		edge_match = (int'(e_from) == int'(best_q)) && (int'(e_from) < int'(n_q))
			&& (int'(e_to) < int'(n_q));
		scan_take = v_s1 && reached_q[idx_s1] && !settled_q[idx_s1]
			&& (!found_q || (dist_rd_q < best_dist_q));
		scan_done = (idx_q == n_q) && !v_s1;
		out_done  = (idx_q == n_q) && !v_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and memory port control.
	always_comb begin
		state_d     = state_q;
		ectrl       = '0;
		mem_rd      = 1'b0;
		mem_rd_addr = idx_q[NODE_W-1:0];
		mem_we      = 1'b0;
		mem_wr_addr = tgt_q;
		mem_wr_dist = cand_q;
		mem_wr_pred = best_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ectrl.load  = (cmd.operation == OP_LOAD);
					ectrl.clear = (cmd.operation == OP_CLEAR);
					if (cmd.operation == OP_RUN) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				// The source starts at distance zero and is its own predecessor.
				mem_we      = src_ok_q;
				mem_wr_addr = src_q;
				mem_wr_dist = '0;
				mem_wr_pred = src_q;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				mem_rd = (idx_q != n_q);
				if (scan_done) begin
					state_d = found_q ? ST_EDGE_RD : ST_OUT;
				end
			end
			ST_EDGE_RD: begin
				if (e_q == e_total) begin
					state_d = ST_SCAN;
				end else begin
					ectrl.rd_en = 1'b1;
					state_d = ST_EDGE_CHK;
				end
			end
			ST_EDGE_CHK: begin
				mem_rd_addr = NODE_W'(e_to);
				mem_rd = edge_match;
				state_d = edge_match ? ST_DIST_CHK : ST_EDGE_RD;
			end
			ST_DIST_CHK: begin
				mem_we = !reached_q[tgt_q] || (cand_q < dist_rd_q);
				state_d = ST_EDGE_RD;
			end
			ST_OUT: begin
				mem_rd = (idx_q != n_q);
				if (out_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Node memories: one write and one registered read per cycle. Writes and
	// reads of the same entry never share a cycle, the sequencer spaces them.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dist_mem[mem_wr_addr] <= mem_wr_dist;
			pred_mem[mem_wr_addr] <= mem_wr_pred;
		end
		if (mem_rd) begin
			dist_rd_q <= dist_mem[mem_rd_addr];
			pred_rd_q <= pred_mem[mem_rd_addr];
		end
	end

	// Reached and settled flags; a run starts with at most the source reached.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= '0;
			settled_q <= '0;
		end else begin
			priority if (state_q == ST_INIT) begin
				settled_q <= '0;
				reached_q <= src_ok_q ? (MAX_NODES'(1) << src_q) : '0;
			end else if (state_q == ST_SCAN && scan_done && found_q) begin
				settled_q[best_q] <= 1'b1;
			end else if (state_q == ST_DIST_CHK && mem_we) begin
				reached_q[tgt_q] <= 1'b1;
			end
		end
	end

	// Sequencer datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			found_q  <= 1'b0;
			src_ok_q <= 1'b0;
		end else begin
			v_s1 <= mem_rd && (state_q == ST_SCAN || state_q == ST_OUT);
			if (accept && cmd.operation == OP_RUN) begin
				src_ok_q <= (int'(cmd.from_node) < int'(n_eff));
			end
			priority if (state_q == ST_INIT) begin
				found_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (scan_take) begin
					found_q <= 1'b1;
				end
			end else if (state_q == ST_EDGE_RD && e_q == e_total) begin
				found_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[NODE_W-1:0];
		if (accept && cmd.operation == OP_RUN) begin
			n_q   <= n_eff;
			src_q <= NODE_W'(cmd.from_node);
		end
		unique case (state_q)
			ST_INIT: begin
				idx_q <= '0;
			end
			ST_SCAN: begin
				if (mem_rd) begin
					idx_q <= idx_q + 1'b1;
				end
				if (scan_take) begin
					best_q      <= idx_s1;
					best_dist_q <= dist_rd_q;
				end
				if (scan_done) begin
					e_q   <= '0;
					idx_q <= '0;
				end
			end
			ST_EDGE_RD: begin
				if (e_q != e_total) begin
					e_q <= e_q + 1'b1;
				end
			end
			ST_EDGE_CHK: begin
				tgt_q  <= NODE_W'(e_to);
				cand_q <= (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
			end
			ST_OUT: begin
				if (mem_rd) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Result transaction: shown for one cycle from the read registers.
	always_comb begin
		result_strobe      = v_s1 && (state_q == ST_OUT);
		result.node        = 5'(idx_s1);
		result.reachable   = reached_q[idx_s1];
		result.distance    = reached_q[idx_s1] ? dist_rd_q : DIST_MAX;
		result.predecessor = reached_q[idx_s1] ? 5'(pred_rd_q) : 5'd0;
		result.last        = (CNT_W'(idx_s1) == n_q - 1'b1);
	end

	`SSP_ASSERT_IMP(a_strobe_busy, clk, arst_n, result_strobe, busy, "result while not busy")
	`SSP_ASSERT_NXT(a_last_ends, clk, arst_n, result_strobe && result.last, !result_strobe,
		"result after last")
	`SSP_ASSERT_NXT(a_run_busy, clk, arst_n, start && !busy && cmd.operation == OP_RUN, busy,
		"run did not start")
	`SSP_ASSERT_IMP(a_cfg_idle, clk, arst_n, cfg_valid && cfg_ready, !busy,
		"config written while busy")

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for single_source_shortest_path: directed table, then random traffic.
// Depends on ssp_pkg and the single_source_shortest_path RTL.
`default_nettype none

module tb_top;
	import ssp_pkg::*;

	// Operation code that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [5:0] count;
		cmd_t       command;
		logic       has_exp;
		result_t    exp_first;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	cmd_t       cmd;
	result_t    result;
	logic       result_strobe;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [5:0] cfg_data;

	// Shadow copy of the block state used by the distance predictor.
	logic [5:0]  shadow_node_count;
	logic [4:0]  store_from [256];
	logic [4:0]  store_to [256];
	logic [15:0] store_weight [256];
	int          stored_edges;

	result_t     pending_results [$];
	result_t     predicted_first;
	int          mismatches;
	int          unexpected;
	int          results_checked;
	int          runs_sent;
	int          loads_sent;
	bit          idling_on;
	stim_row_t   directed [$];

	single_source_shortest_path u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result       (result),
		.result_strobe(result_strobe),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Timeout: %0d results still pending", pending_results.size());
		$display("Some tests failed");
		$finish;
	end

	// Dijkstra over the shadow edge store; queues one expected result per node in use.
	task automatic predict_shortest_paths(input logic [4:0] src);
		int          n;
		int          best;
		bit          found;
		logic [23:0] node_dist [32];
		logic [4:0]  pred [32];
		bit          settled [32];
		bit          reached [32];
		logic [24:0] cand;
		result_t     r;
		n = (shadow_node_count == 0) ? 1 : ((shadow_node_count > 32) ? 32 : shadow_node_count);
		for (int i = 0; i < 32; i++) begin
			node_dist[i] = DIST_MAX;
			pred[i] = '0;
			settled[i] = 1'b0;
			reached[i] = 1'b0;
		end
		if (src < n) begin
			node_dist[src] = '0;
			pred[src] = src;
			reached[src] = 1'b1;
		end
		forever begin
			found = 1'b0;
			best = 0;
			for (int i = 0; i < n; i++)
				if (reached[i] && !settled[i] && (!found || node_dist[i] < node_dist[best])) begin
					best = i;
					found = 1'b1;
				end
			if (!found)
				break;
			settled[best] = 1'b1;
			// Relax the settled node's edges in load order, strict less-than.
			for (int e = 0; e < stored_edges; e++) begin
				if (store_from[e] != best || store_from[e] >= n || store_to[e] >= n)
					continue;
				cand = {1'b0, node_dist[best]} + store_weight[e];
				if (cand > DIST_MAX)
					cand = DIST_MAX;
				if (!reached[store_to[e]] || cand[23:0] < node_dist[store_to[e]]) begin
					node_dist[store_to[e]] = cand[23:0];
					pred[store_to[e]] = best[4:0];
					reached[store_to[e]] = 1'b1;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			r.node = i[4:0];
			r.distance = reached[i] ? node_dist[i] : DIST_MAX;
			r.predecessor = reached[i] ? pred[i] : '0;
			r.reachable = reached[i];
			r.last = (i + 1 == n);
			if (i == 0)
				predicted_first = r;
			pending_results.insert(pending_results.size(), r);
		end
	endtask

	task automatic apply_command(input cmd_t c);
		if (c.operation == OP_LOAD) begin
			loads_sent++;
			if (stored_edges < 256) begin
				store_from[stored_edges] = c.from_node;
				store_to[stored_edges] = c.to_node;
				store_weight[stored_edges] = c.edge_weight;
				stored_edges++;
			end
		end else if (c.operation == OP_RUN) begin
			runs_sent++;
			predict_shortest_paths(c.from_node);
		end else if (c.operation == OP_CLEAR) begin
			stored_edges = 0;
		end
	endtask

	// Sends one command transaction, with an optional random gap first.
	task automatic send_command(input cmd_t c);
		@(negedge clk);
		if (idling_on && $urandom_range(99) < 37) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		apply_command(c);
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_node_count(input logic [5:0] value);
		wait_until_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		shadow_node_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_row(input stim_row_t row);
		directed.insert(directed.size(), row);
	endfunction

	function automatic stim_row_t cmd_row(input logic [1:0] op, input logic [4:0] a,
			input logic [4:0] b, input logic [15:0] w);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CMD;
		row.command = '{operation: op, from_node: a, to_node: b, edge_weight: w};
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [5:0] value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.count = value;
		return row;
	endfunction

	function automatic cmd_t random_command(input int n);
		cmd_t c;
		int   pick;
		pick = $urandom_range(99);
		c.operation = (pick < 72) ? OP_LOAD : (pick < 86) ? OP_RUN :
			(pick < 94) ? OP_CLEAR : OP_UNUSED;
		// Mostly edges among nodes in use, sometimes anything.
		if ($urandom_range(9) < 8) begin
			c.from_node = 5'($urandom_range(n - 1));
			c.to_node = 5'($urandom_range(n - 1));
		end else begin
			c.from_node = 5'($urandom_range(31));
			c.to_node = 5'($urandom_range(31));
		end
		// Small weights make ties likely.
		c.edge_weight = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
		return c;
	endfunction

	// Result checker: each strobed transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_strobe) begin
			if (pending_results.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("Unexpected result: %p", result);
			end else begin
				e = pending_results.pop_front();
				results_checked++;
				if (result.node !== e.node || result.distance !== e.distance ||
						result.predecessor !== e.predecessor ||
						result.reachable !== e.reachable || result.last !== e.last) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("Mismatch: expected %p, got %p", e, result);
				end
			end
		end
	end

	initial begin
		cmd_t    c;
		int      n;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		shadow_node_count = NODE_COUNT_RESET;
		stored_edges = 0;
		predicted_first = '0;
		mismatches = 0;
		unexpected = 0;
		results_checked = 0;
		runs_sent = 0;
		loads_sent = 0;
		idling_on = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: empty store, strict less-than, self loop, back edge,
		// edges and sources outside the node count, unused code, clear, and
		// node counts of zero and above the maximum.
		add_row(cmd_row(OP_RUN, 5'd31, 5'd0, 16'd0));
		directed[$].has_exp = 1'b1;
		directed[$].exp_first = '{5'd0, DIST_MAX, 5'd0, 1'b0, 1'b0};
		add_row(cfg_row(6'd1));
		add_row(cmd_row(OP_RUN, 5'd0, 5'd0, 16'd0));
		directed[$].has_exp = 1'b1;
		directed[$].exp_first = '{5'd0, 24'd0, 5'd0, 1'b1, 1'b1};
		add_row(cfg_row(6'd4));
		add_row(cmd_row(OP_LOAD, 5'd0, 5'd1, 16'hFFFF));
		add_row(cmd_row(OP_LOAD, 5'd1, 5'd2, 16'hFFFF));
		add_row(cmd_row(OP_LOAD, 5'd0, 5'd2, 16'hFFFE));
		add_row(cmd_row(OP_LOAD, 5'd2, 5'd3, 16'd0));
		add_row(cmd_row(OP_LOAD, 5'd3, 5'd3, 16'd5));
		add_row(cmd_row(OP_LOAD, 5'd3, 5'd0, 16'd0));
		add_row(cmd_row(OP_LOAD, 5'd0, 5'd31, 16'd7));
		add_row(cmd_row(OP_LOAD, 5'd31, 5'd1, 16'd0));
		add_row(cmd_row(OP_RUN, 5'd0, 5'd0, 16'd0));
		add_row(cmd_row(OP_RUN, 5'd4, 5'd0, 16'd0));
		directed[$].has_exp = 1'b1;
		directed[$].exp_first = '{5'd0, DIST_MAX, 5'd0, 1'b0, 1'b0};
		add_row(cmd_row(OP_UNUSED, 5'd31, 5'd31, 16'hFFFF));
		add_row(cfg_row(6'd63));
		add_row(cmd_row(OP_RUN, 5'd31, 5'd0, 16'd0));
		add_row(cfg_row(6'd0));
		add_row(cmd_row(OP_RUN, 5'd0, 5'd0, 16'd0));
		add_row(cmd_row(OP_CLEAR, 5'd0, 5'd0, 16'd0));
		add_row(cfg_row(6'd33));
		add_row(cmd_row(OP_RUN, 5'd3, 5'd0, 16'd0));

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				write_node_count(directed[i].count);
			end else begin
				send_command(directed[i].command);
				if (directed[i].has_exp && predicted_first !== directed[i].exp_first) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("Row %0d: expected %p, predicted %p", i,
							directed[i].exp_first, predicted_first);
				end
			end
		end

		// Random phases: new node count, clear, then mostly loads among nodes in use.
		for (int item = 0; item < 130; item++) begin
			if (item % 20 == 0) begin
				case ($urandom_range(5))
					0: write_node_count(6'd32);
					1: write_node_count(6'($urandom_range(63)));
					default: write_node_count(6'($urandom_range(10, 1)));
				endcase
				send_command('{operation: OP_CLEAR, from_node: 5'd0, to_node: 5'd0,
					edge_weight: 16'd0});
			end
			idling_on = !(item >= 60 && item < 100);
			n = (shadow_node_count == 0) ? 1 : ((shadow_node_count > 32) ? 32 : shadow_node_count);
			c = random_command(n);
			send_command(c);
		end
		idling_on = 1'b1;

		wait_until_drained();
		repeat (50) @(posedge clk);
		$display("Covered %0d runs and %0d edge loads; %0d node results checked.",
			runs_sent, loads_sent, results_checked);
		if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d unexpected results", mismatches, unexpected);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/ssp_pkg.sv
rtl/ssp_edge_store.sv
rtl/single_source_shortest_path.sv
sim/tb_top.sv
